>>> rtl/bulk_only_transport_tracker_top_assert.svh
// Assertion macros for the bulk-only transport tracker.
`ifndef BULK_ONLY_TRANSPORT_TRACKER_TOP_ASSERT_SVH
`define BULK_ONLY_TRANSPORT_TRACKER_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define BOTT_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Plain invariant checked on every clock edge outside reset.
`define BOTT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

`endif

>>> rtl/bott_pkg.sv
// Shared types and constants for the bulk-only transport tracker.
package bott_pkg;

    localparam logic [31:0] CbwSignature = 32'h4342_5355;
    localparam logic [31:0] CswSignature = 32'h5342_5355;
    localparam logic [6:0]  CbwSize      = 7'd31;
    localparam logic [7:0]  CbMaxLen     = 8'd16;
    localparam int unsigned DirInBit     = 7;

    typedef enum logic [1:0] {
        OP_WRAPPER  = 2'd0,
        OP_IN_CHUNK = 2'd1,
        OP_OUT_CHUNK = 2'd2,
        OP_DONE     = 2'd3
    } bott_op_t;

    typedef enum logic [2:0] {
        RESP_WRAPPER_OK = 3'd0,
        RESP_STALL      = 3'd1,
        RESP_CHUNK_OK   = 3'd2,
        RESP_CHUNK_REF  = 3'd3,
        RESP_STATUS     = 3'd4
    } bott_resp_t;

    typedef enum logic [1:0] {
        ST_PASSED = 2'd0,
        ST_FAILED = 2'd1,
        ST_PHASE  = 2'd2
    } bott_status_t;

    function automatic bott_status_t pass_fail(input logic failed);
        return failed ? ST_FAILED : ST_PASSED;
    endfunction

endpackage

>>> rtl/bulk_only_transport_tracker_top.sv
// Top level of the bulk-only transport tracker: input register, decode, result register.
//
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid / s_ready | opcode, wrapper fields, chunk fields
//  m_      | out       | m_valid / m_ready | response and status wrapper fields
//
// Each transaction passes through the input register and then the result
// register; one transaction per cycle is sustained while m_ready does not stall.
// The tracker state is updated as a transaction leaves the input register.
// A stall on m_ready holds both stages; s_ready drops only when both are full.
// aresetn is synchronous and clears the valid flags and all tracker state.
`include "bulk_only_transport_tracker_top_assert.svh"

module bulk_only_transport_tracker_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [6:0]  s_wrapper_bytes,
    input  logic [31:0] s_wrapper_signature,
    input  logic [31:0] s_wrapper_tag,
    input  logic [31:0] s_expected_length,
    input  logic [7:0]  s_wrapper_flags,
    input  logic [7:0]  s_unit_number,
    input  logic [7:0]  s_block_length,
    input  logic [7:0]  s_chunk_length,
    input  logic        s_endpoint_ok,
    input  logic        s_command_failed,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_response,
    output logic [31:0] m_status_tag,
    output logic [31:0] m_status_residue,
    output logic [1:0]  m_status_code,
    output logic [31:0] m_pad_count,
    output logic        m_pad_to_host
);

    // input register
    logic                in_valid_reg;
    bott_pkg::bott_op_t  op_reg;
    logic [6:0]          wbytes_reg;
    logic [31:0]         sig_reg;
    logic [31:0]         tag_reg;
    logic [31:0]         elen_reg;
    logic                dir_in_reg;
    logic [7:0]          lun_reg;
    logic [7:0]          cblen_reg;
    logic [7:0]          clen_reg;
    logic                ep_ok_reg;
    logic                failed_reg;

    // tracker state
    logic [31:0] remaining_in_reg,  remaining_in_next;
    logic [31:0] remaining_out_reg, remaining_out_next;
    logic        transfer_error_reg, transfer_error_next;
    logic [31:0] saved_tag_reg,     saved_tag_next;
    logic [31:0] saved_length_reg,  saved_length_next;
    logic        saved_dir_in_reg,  saved_dir_in_next;
    logic [31:0] last_residue_reg,  last_residue_next;

    // result register
    logic                   m_valid_reg;
    bott_pkg::bott_resp_t   response_reg,  response_next;
    logic [31:0]            status_tag_reg, status_tag_next;
    logic [31:0]            residue_reg,   residue_next;
    bott_pkg::bott_status_t code_reg,      code_next;
    logic [31:0]            pad_reg,       pad_next;
    logic                   to_host_reg,   to_host_next;

    logic advance;
    logic wrapper_ok;
    logic [31:0] in_diff;
    logic [31:0] out_diff;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    assign wrapper_ok = (sig_reg == bott_pkg::CbwSignature) && (lun_reg == 8'd0) &&
                        (cblen_reg != 8'd0) && (cblen_reg <= bott_pkg::CbMaxLen);
    assign in_diff  = remaining_in_reg  - {24'd0, clen_reg};
    assign out_diff = remaining_out_reg - {24'd0, clen_reg};

    always_comb begin
        remaining_in_next   = remaining_in_reg;
        remaining_out_next  = remaining_out_reg;
        transfer_error_next = transfer_error_reg;
        saved_tag_next      = saved_tag_reg;
        saved_length_next   = saved_length_reg;
        saved_dir_in_next   = saved_dir_in_reg;
        last_residue_next   = last_residue_reg;
        response_next       = bott_pkg::RESP_STATUS;
        status_tag_next     = 32'd0;
        code_next           = bott_pkg::ST_PASSED;
        pad_next            = 32'd0;
        to_host_next        = 1'b0;

        case (op_reg)
            bott_pkg::OP_WRAPPER: begin
                remaining_in_next   = 32'd0;
                remaining_out_next  = 32'd0;
                transfer_error_next = 1'b0;
                response_next       = bott_pkg::RESP_STALL;
                if (wbytes_reg == bott_pkg::CbwSize) begin
                    saved_tag_next    = tag_reg;
                    saved_length_next = elen_reg;
                    saved_dir_in_next = dir_in_reg;
                    if (wrapper_ok) begin
                        response_next = bott_pkg::RESP_WRAPPER_OK;
                        if (dir_in_reg) begin
                            remaining_in_next = elen_reg;
                        end else begin
                            remaining_out_next = elen_reg;
                        end
                    end
                end
            end
            bott_pkg::OP_IN_CHUNK: begin
                if ({24'd0, clen_reg} > remaining_in_reg) begin
                    transfer_error_next = 1'b1;
                    response_next       = bott_pkg::RESP_CHUNK_REF;
                end else if (!ep_ok_reg) begin
                    response_next = bott_pkg::RESP_CHUNK_REF;
                end else begin
                    remaining_in_next = in_diff;
                    response_next     = bott_pkg::RESP_CHUNK_OK;
                end
            end
            bott_pkg::OP_OUT_CHUNK: begin
                // overrun saturates the count at zero
                if ({24'd0, clen_reg} > remaining_out_reg) begin
                    remaining_out_next  = 32'd0;
                    transfer_error_next = 1'b1;
                end else begin
                    remaining_out_next = out_diff;
                end
                response_next = bott_pkg::RESP_CHUNK_OK;
            end
            bott_pkg::OP_DONE: begin
                response_next   = bott_pkg::RESP_STATUS;
                status_tag_next = saved_tag_reg;
                if (transfer_error_reg || (remaining_in_reg != 32'd0) ||
                    (remaining_out_reg != 32'd0)) begin
                    code_next = bott_pkg::ST_PHASE;
                    if (saved_dir_in_reg && (saved_length_reg != 32'd0)) begin
                        if (transfer_error_reg) begin
                            pad_next = remaining_in_reg;
                        end else if (remaining_in_reg != 32'd0) begin
                            pad_next          = remaining_in_reg;
                            last_residue_next = remaining_in_reg;
                            code_next         = bott_pkg::pass_fail(failed_reg);
                        end
                        to_host_next = (pad_next != 32'd0);
                    end else if (saved_length_reg != 32'd0) begin
                        if (transfer_error_reg) begin
                            pad_next = remaining_out_reg;
                        end else if (remaining_out_reg != 32'd0) begin
                            pad_next          = remaining_out_reg;
                            last_residue_next = remaining_out_reg;
                            code_next         = bott_pkg::pass_fail(failed_reg);
                        end
                    end
                end else begin
                    last_residue_next = 32'd0;
                    code_next         = bott_pkg::pass_fail(failed_reg);
                end
            end
            default: begin
                response_next = bott_pkg::RESP_STATUS;
            end
        endcase
    end

    assign residue_next = (op_reg == bott_pkg::OP_DONE) ? last_residue_next : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            op_reg     <= bott_pkg::bott_op_t'(s_opcode);
            wbytes_reg <= s_wrapper_bytes;
            sig_reg    <= s_wrapper_signature;
            tag_reg    <= s_wrapper_tag;
            elen_reg   <= s_expected_length;
            dir_in_reg <= s_wrapper_flags[bott_pkg::DirInBit];
            lun_reg    <= s_unit_number;
            cblen_reg  <= s_block_length;
            clen_reg   <= s_chunk_length;
            ep_ok_reg  <= s_endpoint_ok;
            failed_reg <= s_command_failed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg        <= 1'b0;
            remaining_in_reg   <= 32'd0;
            remaining_out_reg  <= 32'd0;
            transfer_error_reg <= 1'b0;
            saved_tag_reg      <= 32'd0;
            saved_length_reg   <= 32'd0;
            saved_dir_in_reg   <= 1'b0;
            last_residue_reg   <= 32'd0;
        end else if (advance) begin
            m_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                remaining_in_reg   <= remaining_in_next;
                remaining_out_reg  <= remaining_out_next;
                transfer_error_reg <= transfer_error_next;
                saved_tag_reg      <= saved_tag_next;
                saved_length_reg   <= saved_length_next;
                saved_dir_in_reg   <= saved_dir_in_next;
                last_residue_reg   <= last_residue_next;
            end
        end
        if (advance && in_valid_reg) begin
            response_reg   <= response_next;
            status_tag_reg <= status_tag_next;
            residue_reg    <= residue_next;
            code_reg       <= code_next;
            pad_reg        <= pad_next;
            to_host_reg    <= to_host_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_response       = response_reg;
    assign m_status_tag     = status_tag_reg;
    assign m_status_residue = residue_reg;
    assign m_status_code    = code_reg;
    assign m_pad_count      = pad_reg;
    assign m_pad_to_host    = to_host_reg;

    // only one direction can carry an expected count at a time
    `BOTT_ASSERT_ALWAYS(a_one_direction,
        (remaining_in_reg == 32'd0) || (remaining_out_reg == 32'd0),
        "both IN and OUT counts nonzero")
    `BOTT_ASSERT_IMPLY(a_status_fields_clear,
        m_valid && (m_response != bott_pkg::RESP_STATUS),
        (m_status_tag == 32'd0) && (m_status_residue == 32'd0) && (m_pad_count == 32'd0) &&
        (m_status_code == bott_pkg::ST_PASSED) && !m_pad_to_host,
        "status fields set on a non-status result")
    `BOTT_ASSERT_IMPLY(a_pad_dir_needs_count,
        m_valid && m_pad_to_host,
        (m_pad_count != 32'd0) && (m_status_code != bott_pkg::ST_FAILED || m_pad_count != 32'd0),
        "pad toward host with zero pad count")

endmodule
